FILE: rtl/core/dpb_pkg.sv
// ----------------------------------------------------------------------------
// dpb_pkg
// Shared types and constants for the depth pixel back-projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package dpb_pkg;

    localparam int MAG_W       = 20;  // |col*16 - cx| or |cy - row*16|, Q.4
    localparam int DEPTH_W     = 16;
    localparam int RECIP_W     = 24;
    localparam int ZFULL_W     = DEPTH_W + RECIP_W;  // depth * unit, Q.24
    localparam int MUL_A_W     = MAG_W + RECIP_W;    // widest A operand
    localparam int MUL_B_W     = ZFULL_W;            // widest B operand
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int DIGIT_W     = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;

    localparam logic [2:0] DIG_DEPTH = 3'd2;
    localparam logic [2:0] DIG_RECIP = 3'd3;
    localparam logic [2:0] DIG_ZFULL = 3'd5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_CENTER_X     = 3'd2,
        CFG_CENTER_Y     = 3'd3,
        CFG_INV_FOCAL_X  = 3'd4,
        CFG_INV_FOCAL_Y  = 3'd5,
        CFG_DEPTH_UNIT   = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [12:0]        image_width;
        logic [12:0]        image_height;
        logic [15:0]        center_x_q4;
        logic [15:0]        center_y_q4;
        logic [RECIP_W-1:0] inv_focal_x_q24;
        logic [RECIP_W-1:0] inv_focal_y_q24;
        logic [RECIP_W-1:0] depth_unit_q24;
    } cfg_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_raw;
        logic [7:0]         blue_in;
        logic [7:0]         green_in;
        logic [7:0]         red_in;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [30:0]        point_z;
        logic [7:0]         blue_out;
        logic [7:0]         green_out;
        logic [7:0]         red_out;
    } out_item_t;

    typedef struct packed {
        logic [MAG_W-1:0]   mag_x;
        logic               neg_x;
        logic [MAG_W-1:0]   mag_y;
        logic               neg_y;
        logic [DEPTH_W-1:0] depth;
        logic [7:0]         blue;
        logic [7:0]         green;
        logic [7:0]         red;
    } queue_entry_t;

    typedef struct packed {
        logic               start;
        logic [2:0]         ndig;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_Z,
        BK_PX,
        BK_QX,
        BK_PY,
        BK_QY,
        BK_DONE
    } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/dpb_front.sv
// ----------------------------------------------------------------------------
// dpb_front
// Raster counters, pixel offsets from the principal point, zero-depth drop.
// ----------------------------------------------------------------------------
`default_nettype none

module dpb_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   pixel_valid,
    output logic                        pixel_stall,
    input  wire dpb_pkg::in_item_t      pixel,
    input  wire dpb_pkg::cfg_t          cfg,
    input  wire logic                   q_full,
    output logic                        push,
    output dpb_pkg::queue_entry_t       entry
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int DX_W = dpb_pkg::MAG_W + 2;

    logic [CW-1:0]   col_reg;
    logic [CW-1:0]   col_next;
    logic [RW-1:0]   row_reg;
    logic [RW-1:0]   row_next;
    logic [CW:0]     col_inc;
    logic [RW:0]     row_inc;
    logic            col_wrap;
    logic            row_wrap;
    logic            accept;
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy;
    logic [DX_W-1:0] dx_mag;
    logic [DX_W-1:0] dy_mag;

    assign pixel_stall = q_full;
    assign accept      = pixel_valid && !pixel_stall;
    assign push        = accept && (pixel.depth_raw != '0);

    assign col_inc  = (CW+1)'(col_reg) + 1'b1;
    assign row_inc  = (RW+1)'(row_reg) + 1'b1;
    assign col_wrap = (32'(col_inc) >= 32'(cfg.image_width)) ||
                      (32'(col_inc) >= 32'(MAX_WIDTH));
    assign row_wrap = (32'(row_inc) >= 32'(cfg.image_height)) ||
                      (32'(row_inc) >= 32'(MAX_HEIGHT));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_inc[RW-1:0];
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_comb
    begin
        dx     = $signed(DX_W'({col_reg, 4'b0000})) - $signed(DX_W'(cfg.center_x_q4));
        dy     = $signed(DX_W'(cfg.center_y_q4)) - $signed(DX_W'({row_reg, 4'b0000}));
        dx_mag = dx[DX_W-1] ? DX_W'(-dx) : DX_W'(dx);
        dy_mag = dy[DX_W-1] ? DX_W'(-dy) : DX_W'(dy);

        entry.mag_x = dx_mag[dpb_pkg::MAG_W-1:0];
        entry.neg_x = dx[DX_W-1];
        entry.mag_y = dy_mag[dpb_pkg::MAG_W-1:0];
        entry.neg_y = dy[DX_W-1];
        entry.depth = pixel.depth_raw;
        entry.blue  = pixel.blue_in;
        entry.green = pixel.green_in;
        entry.red   = pixel.red_in;
    end

endmodule

`default_nettype wire

FILE: rtl/core/dpb_queue.sv
// ----------------------------------------------------------------------------
// dpb_queue
// Short FIFO between the pixel front end and the projection back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dpb_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire dpb_pkg::queue_entry_t  wdata,
    input  wire logic                   pop,
    output dpb_pkg::queue_entry_t       rdata,
    output logic [$clog2(dpb_pkg::QUEUE_DEPTH+1)-1:0] level
);

    localparam int PTR_W = $clog2(dpb_pkg::QUEUE_DEPTH);
    localparam int LVL_W = $clog2(dpb_pkg::QUEUE_DEPTH+1);

    dpb_pkg::queue_entry_t slot [dpb_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;

    assign rdata = slot[rd_ptr_reg];
    assign level = level_reg;

    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            level_reg <= level_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/dpb_mul.sv
// ----------------------------------------------------------------------------
// dpb_mul
// Digit-serial multiplier: B is consumed 8 bits per cycle, MSB digit first.
// ----------------------------------------------------------------------------
`default_nettype none

module dpb_mul (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dpb_pkg::mul_req_t             req,
    output logic                               done,
    output logic [dpb_pkg::MUL_P_W-1:0]        prod
);

    localparam int A_W = dpb_pkg::MUL_A_W;
    localparam int B_W = dpb_pkg::MUL_B_W;
    localparam int P_W = dpb_pkg::MUL_P_W;
    localparam int D_W = dpb_pkg::DIGIT_W;

    logic [A_W-1:0]     a_reg;
    logic [B_W-1:0]     b_reg;
    logic [P_W-1:0]     acc_reg;
    logic [2:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [A_W+D_W-1:0] partial;

    assign partial = a_reg * b_reg[B_W-1 -: D_W];
    assign done    = done_reg;
    assign prod    = acc_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg   <= b_reg << D_W;
            acc_reg <= (acc_reg << D_W) + P_W'(partial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg  <= req.ndig;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 3'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/dpb_back.sv
// ----------------------------------------------------------------------------
// dpb_back
// Projection sequencer: z, x and y through the shared multiplier, then the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dpb_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire dpb_pkg::cfg_t              cfg,
    input  wire dpb_pkg::queue_entry_t      q_entry,
    input  wire logic                       q_empty,
    output logic                            pop,
    output dpb_pkg::mul_req_t               mul_req,
    input  wire logic                       mul_done,
    input  wire logic [dpb_pkg::MUL_P_W-1:0] mul_prod,
    output logic                            point_valid,
    input  wire logic                       point_stall,
    output dpb_pkg::out_item_t              point
);

    localparam int A_W = dpb_pkg::MUL_A_W;
    localparam int P_W = dpb_pkg::MUL_P_W;
    localparam int Z_W = dpb_pkg::ZFULL_W;
    localparam int Q_W = P_W - 36;

    dpb_pkg::back_state_t  state_reg;
    dpb_pkg::back_state_t  state_next;
    dpb_pkg::queue_entry_t ent_reg;
    dpb_pkg::out_item_t    out_reg;
    logic [Z_W-1:0]        zfull_reg;
    logic [31:0]           x_reg;
    logic [31:0]           y_reg;
    logic                  out_valid_reg;
    logic                  ent_load;
    logic                  z_load;
    logic                  x_load;
    logic                  y_load;
    logic                  out_load;

    function automatic logic [31:0] sat_coord(input logic [P_W-1:0] p, input logic neg);
        logic [Q_W-1:0] q;
        logic [Q_W-1:0] nq;
        logic [31:0]    r;
        q  = p[P_W-1:36];
        nq = '0 - q;
        if (neg)
        begin
            r = (q > Q_W'(32'h8000_0000)) ? 32'h8000_0000 : nq[31:0];
        end
        else
        begin
            r = (q > Q_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
        end
        return r;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dpb_pkg::BK_IDLE: if (!q_empty) state_next = dpb_pkg::BK_Z;
            dpb_pkg::BK_Z:    if (mul_done) state_next = dpb_pkg::BK_PX;
            dpb_pkg::BK_PX:   if (mul_done) state_next = dpb_pkg::BK_QX;
            dpb_pkg::BK_QX:   if (mul_done) state_next = dpb_pkg::BK_PY;
            dpb_pkg::BK_PY:   if (mul_done) state_next = dpb_pkg::BK_QY;
            dpb_pkg::BK_QY:   if (mul_done) state_next = dpb_pkg::BK_DONE;
            dpb_pkg::BK_DONE: if (!out_valid_reg || !point_stall) state_next = dpb_pkg::BK_IDLE;
            default:          state_next = dpb_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        ent_load = 1'b0;
        z_load   = 1'b0;
        x_load   = 1'b0;
        y_load   = 1'b0;
        out_load = 1'b0;
        mul_req  = '0;
        unique case (state_reg)
            dpb_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop           = 1'b1;
                    ent_load      = 1'b1;
                    mul_req.start = 1'b1;
                    mul_req.ndig  = dpb_pkg::DIG_DEPTH;
                    mul_req.a     = A_W'(cfg.depth_unit_q24);
                    mul_req.b     = {q_entry.depth, 24'b0};
                end
            end
            dpb_pkg::BK_Z:
            begin
                if (mul_done)
                begin
                    z_load        = 1'b1;
                    mul_req.start = 1'b1;
                    mul_req.ndig  = dpb_pkg::DIG_RECIP;
                    mul_req.a     = A_W'(ent_reg.mag_x);
                    mul_req.b     = {cfg.inv_focal_x_q24, 16'b0};
                end
            end
            dpb_pkg::BK_PX:
            begin
                if (mul_done)
                begin
                    mul_req.start = 1'b1;
                    mul_req.ndig  = dpb_pkg::DIG_ZFULL;
                    mul_req.a     = mul_prod[A_W-1:0];
                    mul_req.b     = zfull_reg;
                end
            end
            dpb_pkg::BK_QX:
            begin
                if (mul_done)
                begin
                    x_load        = 1'b1;
                    mul_req.start = 1'b1;
                    mul_req.ndig  = dpb_pkg::DIG_RECIP;
                    mul_req.a     = A_W'(ent_reg.mag_y);
                    mul_req.b     = {cfg.inv_focal_y_q24, 16'b0};
                end
            end
            dpb_pkg::BK_PY:
            begin
                if (mul_done)
                begin
                    mul_req.start = 1'b1;
                    mul_req.ndig  = dpb_pkg::DIG_ZFULL;
                    mul_req.a     = mul_prod[A_W-1:0];
                    mul_req.b     = zfull_reg;
                end
            end
            dpb_pkg::BK_QY:
            begin
                if (mul_done)
                begin
                    y_load = 1'b1;
                end
            end
            dpb_pkg::BK_DONE:
            begin
                if (!out_valid_reg || !point_stall)
                begin
                    out_load = 1'b1;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ent_load)
        begin
            ent_reg <= q_entry;
        end
        if (z_load)
        begin
            zfull_reg <= mul_prod[Z_W-1:0];
        end
        if (x_load)
        begin
            x_reg <= sat_coord(mul_prod, ent_reg.neg_x);
        end
        if (y_load)
        begin
            y_reg <= sat_coord(mul_prod, ent_reg.neg_y);
        end
        if (out_load)
        begin
            out_reg.point_x   <= $signed(x_reg);
            out_reg.point_y   <= $signed(y_reg);
            out_reg.point_z   <= zfull_reg[Z_W-1] ? 31'h7FFF_FFFF : zfull_reg[Z_W-2:8];
            out_reg.blue_out  <= ent_reg.blue;
            out_reg.green_out <= ent_reg.green;
            out_reg.red_out   <= ent_reg.red;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dpb_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!point_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign point_valid = out_valid_reg;
    assign point       = out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/depth_pixel_backprojection.sv
// ----------------------------------------------------------------------------
// depth_pixel_backprojection
// Pinhole back-projection of a raster depth/colour pixel stream to points.
// ----------------------------------------------------------------------------
// Pixels enter in raster order; the column and row counters wrap at the
// configured image size (capped by MAX_WIDTH / MAX_HEIGHT). A zero-depth
// pixel is consumed without being queued and produces no transaction on the
// point side. Every other pixel is queued (two entries) and then projected
// by a sequencer around one shared 8-bit-digit multiplier: z, x and y take
// five products of 2, 3, 5, 3 and 5 digits, and the pixel side stalls once
// the queue holds two pixels. The finished point waits in an output register
// while the next pixel is already being worked on. Configuration writes are
// taken at any time but must only be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_pixel_backprojection #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               pixel_valid,
    output logic                                    pixel_stall,
    input  wire dpb_pkg::in_item_t                  pixel,
    output logic                                    point_valid,
    input  wire logic                               point_stall,
    output dpb_pkg::out_item_t                      point,
    input  wire logic                               cfg_we,
    input  wire logic [dpb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [dpb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int LVL_W = $clog2(dpb_pkg::QUEUE_DEPTH+1);

    dpb_pkg::cfg_t         cfg_reg;
    dpb_pkg::queue_entry_t f_entry;
    dpb_pkg::queue_entry_t q_entry;
    dpb_pkg::mul_req_t     mul_req;
    logic [dpb_pkg::MUL_P_W-1:0] mul_prod;
    logic                  mul_done;
    logic                  push;
    logic                  pop;
    logic [LVL_W-1:0]      q_level;
    logic                  q_full;
    logic                  q_empty;

    assign q_full  = (q_level == LVL_W'(dpb_pkg::QUEUE_DEPTH));
    assign q_empty = (q_level == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width     <= 13'd640;
            cfg_reg.image_height    <= 13'd480;
            cfg_reg.center_x_q4     <= 16'd5208;
            cfg_reg.center_y_q4     <= 16'd4056;
            cfg_reg.inv_focal_x_q24 <= 24'd32388;
            cfg_reg.inv_focal_y_q24 <= 24'd32326;
            cfg_reg.depth_unit_q24  <= 24'd16777;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dpb_pkg::CFG_IMAGE_WIDTH:  cfg_reg.image_width     <= cfg_data[12:0];
                dpb_pkg::CFG_IMAGE_HEIGHT: cfg_reg.image_height    <= cfg_data[12:0];
                dpb_pkg::CFG_CENTER_X:     cfg_reg.center_x_q4     <= cfg_data[15:0];
                dpb_pkg::CFG_CENTER_Y:     cfg_reg.center_y_q4     <= cfg_data[15:0];
                dpb_pkg::CFG_INV_FOCAL_X:  cfg_reg.inv_focal_x_q24 <= cfg_data;
                dpb_pkg::CFG_INV_FOCAL_Y:  cfg_reg.inv_focal_y_q24 <= cfg_data;
                dpb_pkg::CFG_DEPTH_UNIT:   cfg_reg.depth_unit_q24  <= cfg_data;
                default:                   cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    dpb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .cfg         (cfg_reg),
        .q_full      (q_full),
        .push        (push),
        .entry       (f_entry)
    );

    dpb_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (f_entry),
        .pop   (pop),
        .rdata (q_entry),
        .level (q_level)
    );

    dpb_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    dpb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_entry     (q_entry),
        .q_empty     (q_empty),
        .pop         (pop),
        .mul_req     (mul_req),
        .mul_done    (mul_done),
        .mul_prod    (mul_prod),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point)
    );

    // a zero-depth transaction never enters the queue
    a_zero_depth_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_stall && pixel.depth_raw == '0 |=> q_level <= $past(q_level))
        else $error("zero-depth pixel was queued");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= LVL_W'(dpb_pkg::QUEUE_DEPTH))
        else $error("queue overflow");

endmodule

`default_nettype wire
